// ----- sv/hgt_pkg.sv -----
// shared types and constants for the history gravity tables
`timescale 1ns / 1ps
`default_nettype none
package hgt_pkg;

   localparam int SQUARES = 64;
   localparam int SCORE_W = 16;
   localparam int DEPTH_W = 6;
   localparam int MAG_W = 13;
   localparam int PROD_W = SCORE_W + MAG_W + 1;
   localparam int GRAV_SHIFT = 9;
   localparam int BONUS_SHIFT = 5;
   localparam int QUIET_DEPTH = 2 * SQUARES * SQUARES;
   localparam int PREV_MOVE_INDICES_DEF = 512;
   localparam int PIECE_KINDS_DEF = 6;

   typedef enum logic [3:0] {
      OP_QUIET_INC   = 4'd0,
      OP_QUIET_DEC   = 4'd1,
      OP_CAPTURE_INC = 4'd2,
      OP_CAPTURE_DEC = 4'd3,
      OP_COUNTER_INC = 4'd4,
      OP_COUNTER_DEC = 4'd5,
      OP_QUIET_RD    = 4'd6,
      OP_CAPTURE_RD  = 4'd7,
      OP_COUNTER_RD  = 4'd8,
      OP_CLEAR       = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      TBL_NONE,
      TBL_QUIET,
      TBL_CAPTURE,
      TBL_COUNTER
   } tbl_type;

   typedef enum logic [1:0] {
      ADJ_NONE,
      ADJ_MINUS,
      ADJ_PLUS
   } adj_type;

   typedef struct packed {
      logic    neg;
      adj_type adj;
   } bonus_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

// ----- sv/hgt_ram.sv -----
// single-port-write, single-port-read score memory with registered read data
`timescale 1ns / 1ps
`default_nettype none
module hgt_ram #(
   parameter int DEPTH = hgt_pkg::QUIET_DEPTH,
   parameter int AW = $clog2(DEPTH)
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [AW-1:0]               wr_addr,
   input  wire logic [hgt_pkg::SCORE_W-1:0] wr_data,
   input  wire logic [AW-1:0]               rd_addr,
   output logic [hgt_pkg::SCORE_W-1:0]      rd_data
);

   logic [hgt_pkg::SCORE_W-1:0] mem_ff [DEPTH];
   logic [hgt_pkg::SCORE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- sv/hgt_gravity.sv -----
// bonus and gravity update arithmetic, two register stages
`timescale 1ns / 1ps
`default_nettype none
module hgt_gravity (
   input  wire logic                               clock,
   input  wire hgt_pkg::bonus_type                 bonus,
   input  wire logic [hgt_pkg::DEPTH_W-1:0]        depth,
   input  wire logic signed [hgt_pkg::SCORE_W-1:0] cur,
   output logic signed [hgt_pkg::SCORE_W-1:0]      next_score
);

   logic [hgt_pkg::MAG_W-1:0]          depth_ext;
   logic [hgt_pkg::MAG_W-1:0]          square;
   logic [hgt_pkg::MAG_W-1:0]          mag_in;
   logic [hgt_pkg::MAG_W-1:0]          mag_ff;
   logic                               neg_ff;
   logic signed [hgt_pkg::PROD_W-1:0]  prod_in;
   logic signed [hgt_pkg::PROD_W-1:0]  prod_ff;
   logic signed [hgt_pkg::SCORE_W-1:0] cur_ff;
   logic signed [hgt_pkg::PROD_W-1:0]  rounded;
   logic signed [hgt_pkg::PROD_W-1:0]  quot;
   logic [hgt_pkg::SCORE_W-1:0]        scaled;
   logic [hgt_pkg::SCORE_W-1:0]        step;

   // bonus magnitude from depth
   always_comb begin
      depth_ext = hgt_pkg::MAG_W'(depth);
      square = depth_ext * depth_ext;
      case (bonus.adj)
         hgt_pkg::ADJ_MINUS: mag_in = square - depth_ext;
         hgt_pkg::ADJ_PLUS:  mag_in = square + depth_ext;
         default:            mag_in = square;
      endcase
   end

   assign prod_in = cur * $signed({1'b0, mag_ff});

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= bonus.neg;
      prod_ff <= prod_in;
      cur_ff  <= cur;
   end

   // divide by 512 with truncation toward zero
   always_comb begin
      rounded = prod_ff[hgt_pkg::PROD_W-1]
              ? prod_ff + hgt_pkg::PROD_W'((1 << hgt_pkg::GRAV_SHIFT) - 1)
              : prod_ff;
      quot = rounded >>> hgt_pkg::GRAV_SHIFT;
      scaled = hgt_pkg::SCORE_W'({mag_ff, {hgt_pkg::BONUS_SHIFT{1'b0}}});
      step = neg_ff ? -scaled : scaled;
      next_score = cur_ff + step - quot[hgt_pkg::SCORE_W-1:0];
   end

endmodule
`default_nettype wire

// ----- sv/history_gravity_tables.sv -----
// History gravity tables: three signed 16-bit move-ordering score tables
// (quiet, capture, counter-move) held in synchronous memories, updated by
// read, gravity arithmetic and write-back. One transaction is in flight at a
// time. An update or read is accepted in an idle cycle, then passes through
// the memory read, the multiply and the write-back in turn, and its result
// is registered at write-back. A new transaction is accepted only after the
// previous one has left write-back, a limit set by the read-modify-write path
// through the table memory and the two-stage gravity unit. The result
// sits in an output register, so the next transaction may be accepted while
// it waits. A clear, and reset itself, runs a clearing pass that writes one
// entry of every table per cycle over the depth of the largest table; no
// transaction is accepted meanwhile, and a clear returns its zero result at
// the end of the pass.
`timescale 1ns / 1ps
`default_nettype none
module history_gravity_tables #(
   parameter int PREV_MOVE_INDICES = hgt_pkg::PREV_MOVE_INDICES_DEF,
   parameter int PIECE_KINDS = hgt_pkg::PIECE_KINDS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [3:0]                         req_op,
   input  wire logic                               req_side,
   input  wire logic [5:0]                         req_from_square,
   input  wire logic [5:0]                         req_to_square,
   input  wire logic [2:0]                         req_moving_piece,
   input  wire logic [2:0]                         req_captured_piece,
   input  wire logic [8:0]                         req_prev_move_index,
   input  wire logic [5:0]                         req_depth,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [hgt_pkg::SCORE_W-1:0]      rsp_score
);

   localparam int QUIET_DEPTH = hgt_pkg::QUIET_DEPTH;
   localparam int CAP_DEPTH = PIECE_KINDS * PIECE_KINDS * hgt_pkg::SQUARES;
   localparam int CNT_DEPTH = 2 * PREV_MOVE_INDICES * PIECE_KINDS * hgt_pkg::SQUARES;
   localparam int QW = $clog2(QUIET_DEPTH);
   localparam int CW = $clog2(CAP_DEPTH);
   localparam int KW = $clog2(CNT_DEPTH);
   localparam int BIG_DEPTH = (CAP_DEPTH > QUIET_DEPTH) ? CAP_DEPTH : QUIET_DEPTH;
   localparam int SWEEP_DEPTH = (CNT_DEPTH > BIG_DEPTH) ? CNT_DEPTH : BIG_DEPTH;
   localparam int SW = $clog2(SWEEP_DEPTH);

   hgt_pkg::state_type state_ff, state_in;
   hgt_pkg::op_type    op_in;
   hgt_pkg::tbl_type   tbl_in, tbl_ff;
   hgt_pkg::bonus_type bonus_in, bonus_ff;
   logic               update_in, update_ff;
   logic [5:0]         depth_ff;
   logic [QW-1:0]      q_addr_in, q_addr_ff;
   logic [CW-1:0]      c_addr_in, c_addr_ff;
   logic [KW-1:0]      k_addr_in, k_addr_ff;
   logic [SW-1:0]      clr_ff, clr_in;
   logic               clr_resp_ff;
   logic               clr_last;
   logic               accept;
   logic               rsp_free;
   logic               sweep;
   logic               finish;
   logic               commit;
   logic               mover_ok, victim_ok, prev_ok;
   logic               rsp_valid_ff;
   logic signed [hgt_pkg::SCORE_W-1:0] rsp_score_ff;
   logic signed [hgt_pkg::SCORE_W-1:0] score;
   logic signed [hgt_pkg::SCORE_W-1:0] rd_sel;
   logic signed [hgt_pkg::SCORE_W-1:0] next_score;
   logic [hgt_pkg::SCORE_W-1:0] q_rd, c_rd, k_rd;
   logic [hgt_pkg::SCORE_W-1:0] wr_data;
   logic               q_we, c_we, k_we;
   logic [QW-1:0]      q_wa;
   logic [CW-1:0]      c_wa;
   logic [KW-1:0]      k_wa;

   // request decode
   always_comb begin
      op_in = hgt_pkg::op_type'(req_op);
      mover_ok = int'(req_moving_piece) < PIECE_KINDS;
      victim_ok = int'(req_captured_piece) < PIECE_KINDS;
      prev_ok = int'(req_prev_move_index) < PREV_MOVE_INDICES;
      q_addr_in = QW'({req_side, req_from_square, req_to_square});
      c_addr_in = CW'((int'(req_moving_piece) * PIECE_KINDS + int'(req_captured_piece))
                      * hgt_pkg::SQUARES + int'(req_to_square));
      k_addr_in = KW'(((int'(req_side) * PREV_MOVE_INDICES + int'(req_prev_move_index))
                       * PIECE_KINDS + int'(req_moving_piece)) * hgt_pkg::SQUARES
                      + int'(req_to_square));
      tbl_in = hgt_pkg::TBL_NONE;
      update_in = 1'b0;
      bonus_in = '{neg: 1'b0, adj: hgt_pkg::ADJ_NONE};
      unique case (op_in) inside
         hgt_pkg::OP_QUIET_INC, hgt_pkg::OP_QUIET_DEC, hgt_pkg::OP_QUIET_RD: begin
            tbl_in = hgt_pkg::TBL_QUIET;
         end
         hgt_pkg::OP_CAPTURE_INC, hgt_pkg::OP_CAPTURE_DEC, hgt_pkg::OP_CAPTURE_RD: begin
            if (mover_ok && victim_ok) begin
               tbl_in = hgt_pkg::TBL_CAPTURE;
            end
         end
         hgt_pkg::OP_COUNTER_INC, hgt_pkg::OP_COUNTER_DEC, hgt_pkg::OP_COUNTER_RD: begin
            if (mover_ok && prev_ok) begin
               tbl_in = hgt_pkg::TBL_COUNTER;
            end
         end
         default: ;
      endcase
      unique case (op_in)
         hgt_pkg::OP_QUIET_INC: begin
            update_in = 1'b1;
         end
         hgt_pkg::OP_QUIET_DEC: begin
            update_in = 1'b1;
            bonus_in = '{neg: 1'b1, adj: hgt_pkg::ADJ_MINUS};
         end
         hgt_pkg::OP_CAPTURE_INC: begin
            update_in = 1'b1;
         end
         hgt_pkg::OP_CAPTURE_DEC: begin
            update_in = 1'b1;
            bonus_in = '{neg: 1'b1, adj: hgt_pkg::ADJ_NONE};
         end
         hgt_pkg::OP_COUNTER_INC: begin
            update_in = 1'b1;
            bonus_in = '{neg: 1'b0, adj: hgt_pkg::ADJ_PLUS};
         end
         hgt_pkg::OP_COUNTER_DEC: begin
            update_in = 1'b1;
            bonus_in = '{neg: 1'b1, adj: hgt_pkg::ADJ_NONE};
         end
         default: ;
      endcase
   end

   assign clr_last = int'(clr_ff) == SWEEP_DEPTH - 1;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign accept = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hgt_pkg::ST_CLEAR: begin
            if (clr_last) begin
               state_in = clr_resp_ff ? hgt_pkg::ST_DONE : hgt_pkg::ST_IDLE;
            end
         end
         hgt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = (op_in == hgt_pkg::OP_CLEAR) ? hgt_pkg::ST_CLEAR
                                                       : hgt_pkg::ST_READ;
            end
         end
         hgt_pkg::ST_READ: state_in = hgt_pkg::ST_CALC;
         hgt_pkg::ST_CALC: state_in = hgt_pkg::ST_DONE;
         hgt_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = hgt_pkg::ST_IDLE;
            end
         end
         default: state_in = hgt_pkg::ST_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = state_ff != hgt_pkg::ST_IDLE;
      sweep = state_ff == hgt_pkg::ST_CLEAR;
      finish = (state_ff == hgt_pkg::ST_DONE) && rsp_free;
      commit = finish && update_ff;
      clr_in = (sweep && !clr_last) ? clr_ff + 1'b1 : '0;
   end

   // table select and write ports
   always_comb begin
      case (tbl_ff)
         hgt_pkg::TBL_QUIET:   rd_sel = q_rd;
         hgt_pkg::TBL_CAPTURE: rd_sel = c_rd;
         hgt_pkg::TBL_COUNTER: rd_sel = k_rd;
         default:              rd_sel = '0;
      endcase
      if (tbl_ff == hgt_pkg::TBL_NONE) begin
         score = '0;
      end else if (update_ff) begin
         score = next_score;
      end else begin
         score = rd_sel;
      end
      wr_data = sweep ? '0 : next_score;
      q_we = (sweep && int'(clr_ff) < QUIET_DEPTH)
          || (commit && tbl_ff == hgt_pkg::TBL_QUIET);
      c_we = (sweep && int'(clr_ff) < CAP_DEPTH)
          || (commit && tbl_ff == hgt_pkg::TBL_CAPTURE);
      k_we = (sweep && int'(clr_ff) < CNT_DEPTH)
          || (commit && tbl_ff == hgt_pkg::TBL_COUNTER);
      q_wa = sweep ? clr_ff[QW-1:0] : q_addr_ff;
      c_wa = sweep ? clr_ff[CW-1:0] : c_addr_ff;
      k_wa = sweep ? clr_ff[KW-1:0] : k_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hgt_pkg::ST_CLEAR;
         clr_ff       <= '0;
         clr_resp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (accept) begin
            clr_resp_ff <= op_in == hgt_pkg::OP_CLEAR;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tbl_ff    <= tbl_in;
         update_ff <= update_in;
         bonus_ff  <= bonus_in;
         depth_ff  <= req_depth;
         q_addr_ff <= q_addr_in;
         c_addr_ff <= c_addr_in;
         k_addr_ff <= k_addr_in;
      end
      if (finish) begin
         rsp_score_ff <= score;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_score = rsp_score_ff;

   hgt_ram #(
      .DEPTH (QUIET_DEPTH),
      .AW    (QW)
   ) u_quiet (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_wa),
      .wr_data (wr_data),
      .rd_addr (q_addr_ff),
      .rd_data (q_rd)
   );

   hgt_ram #(
      .DEPTH (CAP_DEPTH),
      .AW    (CW)
   ) u_capture (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_wa),
      .wr_data (wr_data),
      .rd_addr (c_addr_ff),
      .rd_data (c_rd)
   );

   hgt_ram #(
      .DEPTH (CNT_DEPTH),
      .AW    (KW)
   ) u_counter (
      .clock   (clock),
      .wr_en   (k_we),
      .wr_addr (k_wa),
      .wr_data (wr_data),
      .rd_addr (k_addr_ff),
      .rd_data (k_rd)
   );

   hgt_gravity u_gravity (
      .clock      (clock),
      .bonus      (bonus_ff),
      .depth      (depth_ff),
      .cur        (rd_sel),
      .next_score (next_score)
   );

   // one transaction in flight
   a_single_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("transaction accepted while another is in flight");

   // a result appears only after the write-back state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == hgt_pkg::ST_DONE))
      else $error("result raised outside write-back");

   // outside a clearing pass, at most one table is written
   a_one_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff != hgt_pkg::ST_CLEAR) |-> $onehot0({q_we, c_we, k_we}))
      else $error("more than one table written by an update");

endmodule
`default_nettype wire

// ----- test/history_gravity_tables_tb.sv -----
// self-checking testbench for the history gravity tables with a scoreboard of expected scores
`timescale 1ns / 1ps
module history_gravity_tables_tb;

   localparam logic [3:0] OP_UNUSED_LO = 4'd10;
   localparam logic [3:0] OP_UNUSED_HI = 4'd15;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int TAIL_CYCLES = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [3:0] req_op = '0;
   logic req_side = 1'b0;
   logic [5:0] req_from_square = '0;
   logic [5:0] req_to_square = '0;
   logic [2:0] req_moving_piece = '0;
   logic [2:0] req_captured_piece = '0;
   logic [8:0] req_prev_move_index = '0;
   logic [5:0] req_depth = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [hgt_pkg::SCORE_W-1:0] rsp_score;

   logic signed [hgt_pkg::SCORE_W-1:0] quiet_scores [int];
   logic signed [hgt_pkg::SCORE_W-1:0] capture_scores [int];
   logic signed [hgt_pkg::SCORE_W-1:0] counter_scores [int];
   logic signed [hgt_pkg::SCORE_W-1:0] expected_scores [$];

   int sender_idle_pct = 37;
   int receiver_idle_pct = 51;
   int failures = 0;
   int cycle_count = 0;

   history_gravity_tables i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_side(req_side),
      .req_from_square(req_from_square),
      .req_to_square(req_to_square),
      .req_moving_piece(req_moving_piece),
      .req_captured_piece(req_captured_piece),
      .req_prev_move_index(req_prev_move_index),
      .req_depth(req_depth),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_score(rsp_score)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   function automatic logic signed [hgt_pkg::SCORE_W-1:0] gravity_entry(
      logic signed [hgt_pkg::SCORE_W-1:0] entry, int bonus);
      int cur;
      int mag;
      int delta;
      logic [31:0] total;
      cur = int'(entry);
      mag = (bonus < 0) ? -bonus : bonus;
      delta = (bonus << hgt_pkg::BONUS_SHIFT) - (cur * mag) / (1 << hgt_pkg::GRAV_SHIFT);
      total = cur + delta;
      return total[hgt_pkg::SCORE_W-1:0];
   endfunction

   function automatic logic signed [hgt_pkg::SCORE_W-1:0] apply_history_op(
      logic [3:0] op, logic side, logic [5:0] from_sq, logic [5:0] to_sq,
      logic [2:0] mover, logic [2:0] victim, logic [8:0] prev, logic [5:0] depth);
      hgt_pkg::tbl_type tbl;
      int idx;
      int d;
      int bonus;
      bit upd;
      logic signed [hgt_pkg::SCORE_W-1:0] cur;
      tbl = hgt_pkg::TBL_NONE;
      idx = 0;
      d = int'(depth);
      bonus = 0;
      upd = 1'b0;
      cur = '0;
      case (op)
         hgt_pkg::OP_QUIET_INC, hgt_pkg::OP_QUIET_DEC, hgt_pkg::OP_QUIET_RD: begin
            tbl = hgt_pkg::TBL_QUIET;
            idx = (int'(side) * hgt_pkg::SQUARES + int'(from_sq)) * hgt_pkg::SQUARES
                  + int'(to_sq);
         end
         hgt_pkg::OP_CAPTURE_INC, hgt_pkg::OP_CAPTURE_DEC, hgt_pkg::OP_CAPTURE_RD: begin
            if (int'(mover) < hgt_pkg::PIECE_KINDS_DEF
                && int'(victim) < hgt_pkg::PIECE_KINDS_DEF) begin
               tbl = hgt_pkg::TBL_CAPTURE;
               idx = (int'(mover) * hgt_pkg::PIECE_KINDS_DEF + int'(victim))
                     * hgt_pkg::SQUARES + int'(to_sq);
            end
         end
         hgt_pkg::OP_COUNTER_INC, hgt_pkg::OP_COUNTER_DEC, hgt_pkg::OP_COUNTER_RD: begin
            if (int'(mover) < hgt_pkg::PIECE_KINDS_DEF
                && int'(prev) < hgt_pkg::PREV_MOVE_INDICES_DEF) begin
               tbl = hgt_pkg::TBL_COUNTER;
               idx = ((int'(side) * hgt_pkg::PREV_MOVE_INDICES_DEF + int'(prev))
                      * hgt_pkg::PIECE_KINDS_DEF + int'(mover))
                     * hgt_pkg::SQUARES + int'(to_sq);
            end
         end
         hgt_pkg::OP_CLEAR: begin
            quiet_scores.delete();
            capture_scores.delete();
            counter_scores.delete();
         end
         default: ;
      endcase
      upd = 1'b1;
      case (op)
         hgt_pkg::OP_QUIET_INC, hgt_pkg::OP_CAPTURE_INC: bonus = d * d;
         hgt_pkg::OP_QUIET_DEC: bonus = -(d * (d - 1));
         hgt_pkg::OP_CAPTURE_DEC, hgt_pkg::OP_COUNTER_DEC: bonus = -(d * d);
         hgt_pkg::OP_COUNTER_INC: bonus = d * d + d;
         default: upd = 1'b0;
      endcase
      case (tbl)
         hgt_pkg::TBL_QUIET: begin
            cur = quiet_scores.exists(idx) ? quiet_scores[idx] : '0;
            if (upd) cur = gravity_entry(cur, bonus);
            quiet_scores[idx] = cur;
         end
         hgt_pkg::TBL_CAPTURE: begin
            cur = capture_scores.exists(idx) ? capture_scores[idx] : '0;
            if (upd) cur = gravity_entry(cur, bonus);
            capture_scores[idx] = cur;
         end
         hgt_pkg::TBL_COUNTER: begin
            cur = counter_scores.exists(idx) ? counter_scores[idx] : '0;
            if (upd) cur = gravity_entry(cur, bonus);
            counter_scores[idx] = cur;
         end
         default: cur = '0;
      endcase
      return cur;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(logic [3:0] op, logic side, logic [5:0] from_sq,
      logic [5:0] to_sq, logic [2:0] mover, logic [2:0] victim, logic [8:0] prev,
      logic [5:0] depth);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_side <= side;
      req_from_square <= from_sq;
      req_to_square <= to_sq;
      req_moving_piece <= mover;
      req_captured_piece <= victim;
      req_prev_move_index <= prev;
      req_depth <= depth;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_scores.push_back(
         apply_history_op(op, side, from_sq, to_sq, mover, victim, prev, depth));
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      logic signed [hgt_pkg::SCORE_W-1:0] exp_score;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_scores.size() == 0) begin
            $error("score: expected none, actual %0d", rsp_score);
            failures++;
         end else begin
            exp_score = expected_scores.pop_front();
            if (rsp_score !== exp_score) begin
               $error("score: expected %0d, actual %0d", exp_score, rsp_score);
               failures++;
            end
         end
      end
   end

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_scores.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_quiet_updates();
      send_item(hgt_pkg::OP_QUIET_INC, 1'b1, 6'd63, 6'd0, 3'd0, 3'd0, 9'd0, 6'd63);
      send_item(hgt_pkg::OP_QUIET_RD, 1'b1, 6'd63, 6'd0, 3'd7, 3'd7, 9'd511, 6'd0);
      send_item(hgt_pkg::OP_QUIET_DEC, 1'b1, 6'd63, 6'd0, 3'd0, 3'd0, 9'd0, 6'd63);
      send_item(hgt_pkg::OP_QUIET_DEC, 1'b1, 6'd63, 6'd0, 3'd0, 3'd0, 9'd0, 6'd1);
      send_item(hgt_pkg::OP_QUIET_INC, 1'b0, 6'd0, 6'd63, 3'd0, 3'd0, 9'd0, 6'd0);
      repeat (3) begin
         send_item(hgt_pkg::OP_QUIET_INC, 1'b0, 6'd0, 6'd63, 3'd5, 3'd5, 9'd0, 6'd40);
      end
   endtask

   task automatic test_capture_updates();
      send_item(hgt_pkg::OP_CAPTURE_INC, 1'b0, 6'd0, 6'd63, 3'd5, 3'd5, 9'd0, 6'd63);
      send_item(hgt_pkg::OP_CAPTURE_DEC, 1'b1, 6'd63, 6'd63, 3'd5, 3'd5, 9'd511, 6'd63);
      send_item(hgt_pkg::OP_CAPTURE_RD, 1'b0, 6'd0, 6'd63, 3'd5, 3'd5, 9'd0, 6'd0);
      send_item(hgt_pkg::OP_CAPTURE_INC, 1'b0, 6'd0, 6'd0, 3'd6, 3'd0, 9'd0, 6'd63);
      send_item(hgt_pkg::OP_CAPTURE_DEC, 1'b0, 6'd0, 6'd0, 3'd0, 3'd7, 9'd0, 6'd63);
      send_item(hgt_pkg::OP_CAPTURE_RD, 1'b0, 6'd0, 6'd0, 3'd7, 3'd0, 9'd0, 6'd0);
   endtask

   task automatic test_counter_updates();
      send_item(hgt_pkg::OP_COUNTER_INC, 1'b1, 6'd0, 6'd63, 3'd5, 3'd0, 9'd511, 6'd63);
      send_item(hgt_pkg::OP_COUNTER_DEC, 1'b1, 6'd0, 6'd63, 3'd5, 3'd0, 9'd511, 6'd63);
      send_item(hgt_pkg::OP_COUNTER_RD, 1'b1, 6'd0, 6'd63, 3'd5, 3'd0, 9'd511, 6'd0);
      send_item(hgt_pkg::OP_COUNTER_INC, 1'b0, 6'd0, 6'd0, 3'd6, 3'd0, 9'd0, 6'd63);
      send_item(hgt_pkg::OP_COUNTER_RD, 1'b0, 6'd0, 6'd0, 3'd7, 3'd0, 9'd0, 6'd0);
   endtask

   task automatic test_unused_ops();
      send_item(OP_UNUSED_LO, 1'b1, 6'd63, 6'd63, 3'd0, 3'd0, 9'd511, 6'd63);
      send_item(OP_UNUSED_HI, 1'b1, 6'd63, 6'd63, 3'd7, 3'd7, 9'd511, 6'd63);
   endtask

   task automatic test_clear();
      send_item(hgt_pkg::OP_CLEAR, 1'b0, 6'd0, 6'd0, 3'd0, 3'd0, 9'd0, 6'd0);
      send_item(hgt_pkg::OP_QUIET_RD, 1'b0, 6'd0, 6'd63, 3'd0, 3'd0, 9'd0, 6'd0);
   endtask

   task automatic test_random_traffic(int count, int send_pct, int recv_pct);
      logic [3:0] op;
      logic side;
      logic [5:0] from_sq;
      logic [5:0] to_sq;
      logic [2:0] mover;
      logic [2:0] victim;
      logic [8:0] prev;
      logic [5:0] depth;
      int pick;
      sender_idle_pct = send_pct;
      receiver_idle_pct = recv_pct;
      repeat (count) begin
         pick = int'($urandom_range(99));
         op = 4'($urandom_range(hgt_pkg::OP_QUIET_INC, hgt_pkg::OP_COUNTER_RD));
         // most traffic hits a few hot entries so scores build up and wrap
         if ($urandom_range(99) < 70) begin
            side = 1'($urandom_range(1));
            from_sq = 6'($urandom_range(3));
            to_sq = 6'($urandom_range(3));
            mover = 3'($urandom_range(1));
            victim = 3'($urandom_range(1));
            prev = 9'($urandom_range(3));
         end else begin
            side = 1'($urandom_range(1));
            from_sq = 6'($urandom_range(63));
            to_sq = 6'($urandom_range(63));
            mover = 3'($urandom_range(hgt_pkg::PIECE_KINDS_DEF - 1));
            victim = 3'($urandom_range(hgt_pkg::PIECE_KINDS_DEF - 1));
            prev = 9'($urandom_range(hgt_pkg::PREV_MOVE_INDICES_DEF - 1));
         end
         depth = 6'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(12));
         if (pick < 4) begin
            op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
         end else if (pick < 10) begin
            mover = 3'($urandom_range(hgt_pkg::PIECE_KINDS_DEF, 7));
         end else if (pick < 14) begin
            victim = 3'($urandom_range(hgt_pkg::PIECE_KINDS_DEF, 7));
         end
         send_item(op, side, from_sq, to_sq, mover, victim, prev, depth);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_quiet_updates();
      test_capture_updates();
      test_counter_updates();
      test_unused_ops();
      test_clear();
      test_random_traffic(240, 37, 51);
      wait_for_results();
      test_random_traffic(240, 51, 37);
      wait_for_results();
      test_random_traffic(220, 0, 0);
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
